/* rtl/core/cv1_pkg.sv */
// ----------------------------------------------------------------------------
// cv1_pkg
// shared constants, types and codes of the 1d convolution engine
// ----------------------------------------------------------------------------
package cv1_pkg;

	localparam int MAX_IN_CH  = 16;
	localparam int MAX_OUT_CH = 16;
	localparam int MAX_KERNEL = 8;
	localparam int DATA_W     = 16;

	localparam int IC_W    = $clog2(MAX_IN_CH);
	localparam int OC_W    = $clog2(MAX_OUT_CH);
	localparam int K_W     = $clog2(MAX_KERNEL);
	localparam int WDEPTH  = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL;
	localparam int WADDR_W = $clog2(WDEPTH);
	localparam int POS_W   = 12;
	localparam int PROD_W  = 2 * DATA_W;
	localparam int ACC_W   = PROD_W + WADDR_W + 2;
	localparam int FRAC_SH = 14;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	typedef enum logic [1:0] {
		OP_WEIGHT = 2'd0,
		OP_BIAS   = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_IN_CH  = 2'd0,
		REG_OUT_CH = 2'd1,
		REG_KTAPS  = 2'd2,
		REG_RELU   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_FIN
	} state_t;

	typedef logic [MAX_IN_CH-1:0][DATA_W-1:0] row_t;

	// clamped configuration seen by the datapath
	typedef struct packed {
		logic [4:0] nin;
		logic [4:0] nout;
		logic [3:0] ktaps;
		logic       relu;
	} cfg_t;

endpackage

/* rtl/core/cv1_if.sv */
// ----------------------------------------------------------------------------
// cv1 stream interfaces
// valid/ready channels for input items and results
// ----------------------------------------------------------------------------
interface cv1_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [10:0] address;
	logic signed [15:0] value;
	logic        start_sequence;

	modport source (output valid, operation, address, value, start_sequence, input ready);
	modport sink   (input valid, operation, address, value, start_sequence, output ready);
endinterface

interface cv1_out_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] out_value;
	logic [3:0]  out_channel;
	logic [11:0] position;
	logic        saturated;
	logic        last;

	modport source (output valid, out_value, out_channel, position, saturated, last,
		input ready);
	modport sink   (input valid, out_value, out_channel, position, saturated, last,
		output ready);
endinterface

/* rtl/core/cv1_tap_cell.sv */
// ----------------------------------------------------------------------------
// cv1_tap_cell
// one window position of samples; rotates to its neighbor on position end
// ----------------------------------------------------------------------------
module cv1_tap_cell
	import cv1_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IC_W-1:0]   wr_ch,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              shift_en,
	input  row_t              row_in,
	output row_t              row_out,
	input  logic [IC_W-1:0]   rd_ch,
	output logic [DATA_W-1:0] rd_data
);

	row_t row_q;
	row_t row_w;

	// a write lands before the row moves on
	always_comb begin
		row_w = row_q;
		if (wr_en) begin
			row_w[wr_ch] = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			row_q <= row_in;
		end else begin
			row_q <= row_w;
		end
	end

	assign row_out = row_w;
	assign rd_data = row_q[rd_ch];

endmodule

/* rtl/core/cv1_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cv1_cfg_regs
// apb register file with count clamping
// ----------------------------------------------------------------------------
module cv1_cfg_regs
	import cv1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [4:0] in_ch_q;
	logic [4:0] out_ch_q;
	logic [3:0] ktaps_q;
	logic       relu_q;
	logic       wr;
	reg_idx_t   idx;

	assign idx   = reg_idx_t'(paddr[3:2]);
	assign wr    = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q  <= 5'd1;
			out_ch_q <= 5'd1;
			ktaps_q  <= 4'd3;
			relu_q   <= 1'b1;
		end else if (wr) begin
			case (idx)
				REG_IN_CH:  in_ch_q  <= pwdata[4:0];
				REG_OUT_CH: out_ch_q <= pwdata[4:0];
				REG_KTAPS:  ktaps_q  <= pwdata[3:0];
				REG_RELU:   relu_q   <= pwdata[0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_IN_CH:  prdata = {27'd0, in_ch_q};
			REG_OUT_CH: prdata = {27'd0, out_ch_q};
			REG_KTAPS:  prdata = {28'd0, ktaps_q};
			REG_RELU:   prdata = {31'd0, relu_q};
			default:    prdata = '0;
		endcase
	end

	// the datapath sees zero as one and too large as the maximum
	always_comb begin
		cfg.nin   = (in_ch_q == 5'd0) ? 5'd1 :
			(in_ch_q > 5'(MAX_IN_CH)) ? 5'(MAX_IN_CH) : in_ch_q;
		cfg.nout  = (out_ch_q == 5'd0) ? 5'd1 :
			(out_ch_q > 5'(MAX_OUT_CH)) ? 5'(MAX_OUT_CH) : out_ch_q;
		cfg.ktaps = (ktaps_q == 4'd0) ? 4'd1 :
			(ktaps_q > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : ktaps_q;
		cfg.relu  = relu_q;
	end

endmodule

/* rtl/core/conv1d_valid_relu_engine_top.sv */
// ----------------------------------------------------------------------------
// conv1d_valid_relu_engine_top
// streaming 1d convolution, valid padding, stride 1, optional relu
// ----------------------------------------------------------------------------
// channel   | dir | handshake        | transaction
// samples   | in  | valid/ready      | weight load, bias load or one sample value
// results   | out | valid/ready      | one output channel of a finished position
// apb       | in  | psel/penable     | register write or read, pready always high
//
// loads and samples that do not finish a window are taken while the engine idles
// a finished position holds ready low while, for each output channel, it runs
//   one multiply-accumulate per cycle through the single weight memory port,
//   then drains the pipeline and hands off the result
// a result still waiting in the result register stretches each hand-off
// a sample that starts a new sequence first waits while the window ring turns
//   back to its home cell
// the result register lets the engine go on while a result waits to be taken
// reset clears control state only; weights, biases and samples need loading
// ----------------------------------------------------------------------------
module conv1d_valid_relu_engine_top
	import cv1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cv1_in_if.sink      samples,
	cv1_out_if.source   results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg;

	cv1_cfg_regs u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	// ---------------- input side ----------------
	logic in_acc;
	logic is_samp;
	op_t  op;
	logic [K_W-1:0] head_q;
	logic realign;

	state_t state_q, state_d;

	assign op      = op_t'(samples.operation);
	// a new sequence begins with the ring at its home cell
	assign realign = samples.valid && (op == OP_SAMPLE) && samples.start_sequence &&
		(head_q != '0) && (state_q == ST_IDLE);
	assign samples.ready = (state_q == ST_IDLE) && !realign;
	assign in_acc  = samples.valid && samples.ready;
	assign is_samp = in_acc && (op == OP_SAMPLE);

	// sequence bookkeeping
	logic [IC_W-1:0]  cc_q;
	logic [POS_W-1:0] pos_q;
	logic [K_W:0]     fill_q;

	logic [IC_W-1:0]  eff_cc;
	logic [4:0]       cc_inc;
	logic [POS_W-1:0] eff_pos;
	logic [K_W:0]     eff_fill;
	logic [K_W:0]     fill_next;
	logic             complete;
	logic             go;

	always_comb begin
		eff_cc   = samples.start_sequence ? '0 : cc_q;
		eff_pos  = samples.start_sequence ? '0 : pos_q;
		eff_fill = samples.start_sequence ? '0 : fill_q;
		// a channel count past a shrunken in_channels lands on the last channel
		if ({1'b0, eff_cc} >= cfg.nin) begin
			eff_cc = IC_W'(cfg.nin - 5'd1);
		end
		cc_inc    = {1'b0, eff_cc} + 5'd1;
		complete  = (cc_inc >= cfg.nin);
		fill_next = (eff_fill < (K_W+1)'(MAX_KERNEL)) ? eff_fill + 1'b1 : eff_fill;
		go        = is_samp && complete && ({1'b0, fill_next} >= (K_W+2)'(cfg.ktaps));
	end

	logic [POS_W-1:0] run_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q   <= '0;
			pos_q  <= '0;
			fill_q <= '0;
		end else if (is_samp) begin
			cc_q   <= complete ? '0 : cc_inc[IC_W-1:0];
			fill_q <= complete ? fill_next : eff_fill;
			if (go && eff_pos != POS_MAX) begin
				pos_q <= eff_pos + 1'b1;
			end else begin
				pos_q <= eff_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			run_pos_q <= eff_pos;
		end
	end

	// ---------------- window: ring of tap cells ----------------
	// cell 0 collects the current position; on completion or realignment every row
	// moves one cell on and the oldest row wraps into cell 0
	row_t              rows   [MAX_KERNEL];
	logic [DATA_W-1:0] taps_rd[MAX_KERNEL];
	logic [IC_W-1:0]   ic_q;
	logic              shift;

	assign shift = (is_samp && complete) || realign;

	// ring turns since reset, modulo the ring length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (shift) begin
			head_q <= head_q + 1'b1;
		end
	end

	for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_cell
		cv1_tap_cell u_cell (
			.clk,
			.wr_en   ((j == 0) ? is_samp : 1'b0),
			.wr_ch   (eff_cc),
			.wr_data (samples.value),
			.shift_en(shift),
			.row_in  (rows[(j + MAX_KERNEL - 1) % MAX_KERNEL]),
			.row_out (rows[j]),
			.rd_ch   (ic_q),
			.rd_data (taps_rd[j])
		);
	end

	// ---------------- coefficient stores ----------------
	logic [DATA_W-1:0]  wmem [WDEPTH];
	logic [DATA_W-1:0]  bias_q [MAX_OUT_CH];
	logic [WADDR_W-1:0] widx_q;
	logic [DATA_W-1:0]  w_s1;

	always_ff @(posedge clk) begin
		if (in_acc && op == OP_WEIGHT) begin
			wmem[samples.address[WADDR_W-1:0]] <= samples.value;
		end
		w_s1 <= wmem[widx_q];
	end

	always_ff @(posedge clk) begin
		if (in_acc && op == OP_BIAS && samples.address[10:OC_W] == '0) begin
			bias_q[samples.address[OC_W-1:0]] <= samples.value;
		end
	end

	// ---------------- mac sequencer ----------------
	logic [OC_W-1:0] oc_q;
	logic [K_W-1:0]  k_q;
	logic            issue;
	logic            last_term;
	logic            load_acc;
	logic [OC_W-1:0] acc_oc;
	logic            load_out;
	logic            vld_s1, vld_s2;
	logic            oc_last;
	logic            out_free;
	logic            out_valid_q;

	assign last_term = ({1'b0, ic_q} == cfg.nin - 5'd1) &&
		({1'b0, k_q} == cfg.ktaps - 4'd1);
	assign oc_last   = ({1'b0, oc_q} == cfg.nout - 5'd1);
	assign out_free  = !out_valid_q || results.ready;

	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		load_acc = 1'b0;
		acc_oc   = '0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (go) begin
					state_d  = ST_MAC;
					load_acc = 1'b1;
				end
			end
			ST_MAC: begin
				issue = 1'b1;
				if (last_term) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					load_out = 1'b1;
					if (oc_last) begin
						state_d = ST_IDLE;
					end else begin
						state_d  = ST_MAC;
						load_acc = 1'b1;
						acc_oc   = oc_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// loop counters: weight index simply walks up across the whole run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_q   <= '0;
			k_q    <= '0;
			ic_q   <= '0;
			widx_q <= '0;
		end else if (go) begin
			oc_q   <= '0;
			k_q    <= '0;
			ic_q   <= '0;
			widx_q <= '0;
		end else begin
			if (issue) begin
				widx_q <= widx_q + 1'b1;
				if ({1'b0, ic_q} == cfg.nin - 5'd1) begin
					ic_q <= '0;
					k_q  <= last_term ? '0 : k_q + 1'b1;
				end else begin
					ic_q <= ic_q + 1'b1;
				end
			end
			if (load_out && !oc_last) begin
				oc_q <= oc_q + 1'b1;
			end
		end
	end

	// tap k reads cell ktaps-k of the ring (modulo the ring length)
	logic [K_W-1:0]    cell_sel;
	logic [DATA_W-1:0] samp_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	assign cell_sel = cfg.ktaps[K_W-1:0] - k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		samp_s1 <= taps_rd[cell_sel];
		prod_s2 <= $signed(w_s1) * $signed(samp_s1);
		if (load_acc) begin
			acc_q <= ACC_W'($signed(bias_q[acc_oc])) <<< FRAC_SH;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// ---------------- rounding, saturation, relu ----------------
	logic signed [ACC_W-1:0]          rnd;
	logic signed [ACC_W-FRAC_SH-1:0]  shr;
	logic signed [DATA_W-1:0]         res;
	logic                             sat;
	localparam logic signed [ACC_W-FRAC_SH-1:0] VMAX = (1 <<< (DATA_W - 1)) - 1;
	localparam logic signed [ACC_W-FRAC_SH-1:0] VMIN = -(1 <<< (DATA_W - 1));

	always_comb begin
		rnd = acc_q + ACC_W'(1 << (FRAC_SH - 1));
		shr = rnd[ACC_W-1:FRAC_SH];
		sat = 1'b0;
		res = shr[DATA_W-1:0];
		if (shr > VMAX) begin
			res = VMAX[DATA_W-1:0];
			sat = 1'b1;
		end else if (shr < VMIN) begin
			res = VMIN[DATA_W-1:0];
			sat = 1'b1;
		end
		if (cfg.relu && res[DATA_W-1]) begin
			res = '0;
		end
	end

	// ---------------- result register ----------------
	logic [DATA_W-1:0] ov_q;
	logic [OC_W-1:0]   och_q;
	logic [POS_W-1:0]  opos_q;
	logic              osat_q, olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			ov_q    <= res;
			och_q   <= oc_q;
			opos_q  <= run_pos_q;
			osat_q  <= sat;
			olast_q <= oc_last;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.out_value   = ov_q;
	assign results.out_channel = och_q;
	assign results.position    = opos_q;
	assign results.saturated   = osat_q;
	assign results.last        = olast_q;

`ifndef SYNTHESIS
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && !results.ready) |=> state_q == ST_FIN)
		else $error("finish left while result register busy");
	a_pipe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (state_q == ST_MAC || state_q == ST_DRAIN))
		else $error("product in flight outside accumulation");
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (K_W+1)'(MAX_KERNEL))
		else $error("window fill count overflow");
	a_oc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ({1'b0, oc_q} < cfg.nout))
		else $error("output channel counter out of range");
	a_load_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && oc_last) |=> (state_q == ST_IDLE && results.last))
		else $error("run did not end on last channel");
`endif

endmodule
